### hw/rtl/line_raster_framebuffer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line raster framebuffer
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTER_FRAMEBUFFER_ASSERT_SVH
`define LINE_RASTER_FRAMEBUFFER_ASSERT_SVH

// same-cycle implication
`define LRF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lrf_pkg.sv
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared types and constants of the line raster framebuffer.
// ----------------------------------------------------------------------------
package lrf_pkg;

    localparam int FB_BYTES_DEF  = 32768;
    localparam int ROW_BYTES_DEF = 90;

    localparam int LOC_W      = 17;   // byte location, wide enough for any legal geometry
    localparam int XW         = 10;   // clamped x
    localparam int YW         = 9;    // clamped y
    localparam int CNT_W      = 11;
    localparam int BANK_SHIFT = 13;
    localparam int MAX_X      = 719;
    localparam int MAX_Y      = 347;

    typedef enum logic [1:0] {
        OP_XOR,
        OP_SET,
        OP_CLR
    } lrf_op_e;

    // one framebuffer access request
    typedef struct packed {
        logic             valid;
        logic             wr;     // read-modify-write; 0 = plain read
        logic [LOC_W-1:0] addr;
        logic [7:0]       mask;
    } lrf_req_t;

    typedef struct packed {
        logic       clearing;
        logic [7:0] rd_value;
    } lrf_mem_stat_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } lrf_walk_stat_t;

endpackage

### hw/rtl/lrf_frame_mem.sv
// ----------------------------------------------------------------------------
// lrf_frame_mem
// Framebuffer store with a one-pixel-per-cycle read-modify-write pipe,
// write forwarding and a clearing pass after reset.
// ----------------------------------------------------------------------------
module lrf_frame_mem #(
    parameter int FB_BYTES = lrf_pkg::FB_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lrf_pkg::lrf_req_t      req,
    input  lrf_pkg::lrf_op_e       op,
    output lrf_pkg::lrf_mem_stat_t stat
);

    localparam int AW = $clog2(FB_BYTES);

    logic [7:0] mem [FB_BYTES];

    logic                      clearing_reg, clearing_next;
    logic [AW-1:0]             clr_cnt_reg, clr_cnt_next;
    logic                      s1_valid_reg, s1_wr_reg;
    logic [AW-1:0]             s1_addr_reg;
    logic [7:0]                s1_mask_reg;
    logic [7:0]                rd_data_reg;
    logic                      fwd_valid_reg, fwd_valid_next;
    logic [AW-1:0]             fwd_addr_reg;
    logic [7:0]                fwd_data_reg;

    logic [7:0]                cur;
    logic [7:0]                upd;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [7:0]                wr_data;

    // previous write has not reached the array when this read was issued
    assign cur = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : rd_data_reg;

    always_comb begin
        case (op)
            lrf_pkg::OP_XOR: upd = cur ^ s1_mask_reg;
            lrf_pkg::OP_SET: upd = cur | s1_mask_reg;
            default:         upd = cur & ~s1_mask_reg;
        endcase
    end

    always_comb begin
        clearing_next  = clearing_reg;
        clr_cnt_next   = clr_cnt_reg;
        fwd_valid_next = 1'b0;
        if (clearing_reg) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = 8'h00;
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(FB_BYTES - 1)) begin
                clearing_next = 1'b0;
            end
        end else begin
            wr_en   = s1_valid_reg && s1_wr_reg;
            wr_addr = s1_addr_reg;
            wr_data = upd;
            fwd_valid_next = wr_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            s1_valid_reg  <= req.valid;
            fwd_valid_reg <= fwd_valid_next;
        end
        s1_wr_reg    <= req.wr;
        s1_addr_reg  <= req.addr[AW-1:0];
        s1_mask_reg  <= req.mask;
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[req.addr[AW-1:0]];
    end

    assign stat.clearing = clearing_reg;
    assign stat.rd_value = cur;

endmodule

### hw/rtl/lrf_line_walker.sv
// ----------------------------------------------------------------------------
// lrf_line_walker
// Bresenham stepper: setup states W_DIFF and W_SETUP, then one pixel request per cycle.
// ----------------------------------------------------------------------------
module lrf_line_walker #(
    parameter int FB_BYTES  = lrf_pkg::FB_BYTES_DEF,
    parameter int ROW_BYTES = lrf_pkg::ROW_BYTES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [lrf_pkg::XW-1:0]  x1,
    input  logic [lrf_pkg::YW-1:0]  y1,
    input  logic [lrf_pkg::XW-1:0]  x2,
    input  logic [lrf_pkg::YW-1:0]  y2,
    output lrf_pkg::lrf_req_t       req,
    output lrf_pkg::lrf_walk_stat_t stat
);

    localparam int CW = lrf_pkg::XW;   // major/minor coordinate width
    localparam int DW = CW + 3;        // error term, signed
    localparam int LW = lrf_pkg::LOC_W;

    typedef enum logic [1:0] {
        W_IDLE,
        W_DIFF,
        W_SETUP,
        W_RUN
    } wstate_t;

    wstate_t                 wstate_reg;
    logic [CW-1:0]           x1_reg, y1_reg, x2_reg, y2_reg;
    logic [CW-1:0]           adx_reg, ady_reg;
    logic                    negx_reg, negy_reg;
    logic                    xmaj_reg, step_neg_reg;
    logic [CW-1:0]           maj_reg, min_reg, end_reg;
    logic signed [DW-1:0]    d_reg, inc_a_reg, inc_b_reg;
    logic [lrf_pkg::CNT_W-1:0] count_reg;

    logic signed [CW:0]      ddx, ddy;
    logic                    xmaj;
    logic [CW-1:0]           amaj, amin;
    logic [CW-1:0]           px, py;
    logic [LW-1:0]           loc;

    assign ddx  = $signed({1'b0, x2_reg}) - $signed({1'b0, x1_reg});
    assign ddy  = $signed({1'b0, y2_reg}) - $signed({1'b0, y1_reg});
    assign xmaj = ady_reg <= adx_reg;
    assign amaj = xmaj ? adx_reg : ady_reg;
    assign amin = xmaj ? ady_reg : adx_reg;

    assign px  = xmaj_reg ? maj_reg : min_reg;
    assign py  = xmaj_reg ? min_reg : maj_reg;
    assign loc = (LW'(py[1:0]) << lrf_pkg::BANK_SHIFT)
               + LW'(ROW_BYTES) * LW'(py[CW-1:2]) + LW'(px[CW-1:3]);

    assign req.valid = wstate_reg == W_RUN;
    assign req.wr    = loc < LW'(FB_BYTES);
    assign req.addr  = loc;
    assign req.mask  = 8'h80 >> px[2:0];

    assign stat.busy  = wstate_reg != W_IDLE;
    assign stat.count = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wstate_reg <= W_IDLE;
        end else begin
            unique case (wstate_reg)
                W_IDLE: begin
                    if (start) begin
                        x1_reg     <= x1;
                        y1_reg     <= CW'(y1);
                        x2_reg     <= x2;
                        y2_reg     <= CW'(y2);
                        count_reg  <= '0;
                        wstate_reg <= W_DIFF;
                    end
                end
                W_DIFF: begin
                    negx_reg   <= ddx[CW];
                    negy_reg   <= ddy[CW];
                    adx_reg    <= ddx[CW] ? CW'(-ddx) : CW'(ddx);
                    ady_reg    <= ddy[CW] ? CW'(-ddy) : CW'(ddy);
                    wstate_reg <= W_SETUP;
                end
                W_SETUP: begin
                    xmaj_reg     <= xmaj;
                    step_neg_reg <= negx_reg ^ negy_reg;
                    if (xmaj ? negx_reg : negy_reg) begin
                        maj_reg <= xmaj ? x2_reg : y2_reg;
                        min_reg <= xmaj ? y2_reg : x2_reg;
                        end_reg <= xmaj ? x1_reg : y1_reg;
                    end else begin
                        maj_reg <= xmaj ? x1_reg : y1_reg;
                        min_reg <= xmaj ? y1_reg : x1_reg;
                        end_reg <= xmaj ? x2_reg : y2_reg;
                    end
                    d_reg      <= (DW'(amin) <<< 1) - DW'(amaj);
                    inc_a_reg  <= DW'(amin) <<< 1;
                    inc_b_reg  <= (DW'(amin) <<< 1) - (DW'(amaj) <<< 1);
                    wstate_reg <= W_RUN;
                end
                W_RUN: begin
                    count_reg <= count_reg + 1'b1;
                    if (maj_reg == end_reg) begin
                        wstate_reg <= W_IDLE;
                    end else begin
                        maj_reg <= maj_reg + 1'b1;
                        if (d_reg[DW-1]) begin
                            d_reg <= d_reg + inc_a_reg;
                        end else begin
                            min_reg <= step_neg_reg ? min_reg - 1'b1 : min_reg + 1'b1;
                            d_reg   <= d_reg + inc_b_reg;
                        end
                    end
                end
                default: wstate_reg <= W_IDLE;
            endcase
        end
    end

endmodule

### hw/rtl/line_raster_framebuffer.sv
// ----------------------------------------------------------------------------
// line_raster_framebuffer
// Pen-plotter command engine over a four-way interleaved monochrome
// framebuffer: move pen, draw line (Bresenham), read byte.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_        in   s_tvalid / s_tready    tuser: func; tdata: pos_x, pos_y, read_address
//  m_        out  m_tvalid / m_tready    tdata: read_data, pixels_plotted
//  cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
//  A draw plots n pixels (up to 720), one read-modify-write per cycle on the
//  single framebuffer port.
//  After reset the framebuffer is zeroed one byte a cycle, with s_tready low;
//  configuration writes are taken throughout.
//  One word is in flight at a time; the result sits in an output register so
//  the next word is taken while m_tready is low.
// ----------------------------------------------------------------------------
`include "line_raster_framebuffer_assert.svh"

module line_raster_framebuffer #(
    parameter int FB_BYTES  = lrf_pkg::FB_BYTES_DEF,
    parameter int ROW_BYTES = lrf_pkg::ROW_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,     // [1:0] func
    input  logic [47:0] s_tdata,     // [15:0] pos_x, [31:16] pos_y, [46:32] read_address
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [7:0] read_data, [18:8] pixels_plotted
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int XW      = lrf_pkg::XW;
    localparam int YW      = lrf_pkg::YW;
    localparam int CNT_W   = lrf_pkg::CNT_W;
    localparam int LW      = lrf_pkg::LOC_W;
    localparam int PEN_W   = 12;        // scaled coordinates, signed
    localparam int PROD_W  = 33;
    localparam int QX_W    = 11;
    localparam int QY_W    = 10;
    // exact divide of a 16-bit magnitude: q = (a * MUL) >> SHIFT
    localparam logic [16:0] DIV31_MUL   = 17'd67651;
    localparam int          DIV31_SHIFT = 21;
    localparam logic [16:0] DIV47_MUL   = 17'd89241;
    localparam int          DIV47_SHIFT = 22;
    localparam int          CNT_MAX     = lrf_pkg::MAX_X + 1;

    localparam logic [1:0] FUNC_MOVE = 2'd0;
    localparam logic [1:0] FUNC_DRAW = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam logic CFG_COLOR_MODE = 1'b0;
    localparam logic CFG_SCREEN_REV = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCALE,
        ST_FIX,
        ST_DRAW,
        ST_RD,
        ST_RDW,
        ST_DONE
    } state_t;

    function automatic logic [XW-1:0] clamp_coord(logic signed [PEN_W-1:0] v, int hi);
        logic [XW-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > hi) begin
            r = XW'(hi);
        end else begin
            r = v[XW-1:0];
        end
        return r;
    endfunction

    state_t                    state_reg, state_next;
    logic [1:0]                func_reg, func_next;
    logic                      negx_reg, negx_next, negy_reg, negy_next;
    logic [15:0]               absx_reg, absx_next, absy_reg, absy_next;
    logic [14:0]               raddr_reg, raddr_next;
    logic [PROD_W-1:0]         prodx_reg, prodx_next, prody_reg, prody_next;
    logic signed [PEN_W-1:0]   pen_x_reg, pen_x_next, pen_y_reg, pen_y_next;
    logic [7:0]                color_reg, color_next;
    logic                      rev_reg, rev_next;
    logic [7:0]                rdata_reg, rdata_next;
    logic [CNT_W-1:0]          rcnt_reg, rcnt_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [23:0]               m_tdata_reg, m_tdata_next;

    logic [15:0]               pos_x, pos_y;
    logic [14:0]               rd_addr_in;
    logic signed [PEN_W-1:0]   sx, sy_s, sy;
    logic [XW-1:0]             nx, ox;
    logic [XW-1:0]             ny, oy;
    logic                      walk_start;
    lrf_pkg::lrf_req_t         walk_req, rd_req, mem_req;
    lrf_pkg::lrf_walk_stat_t   walk_stat;
    lrf_pkg::lrf_mem_stat_t    mem_stat;
    lrf_pkg::lrf_op_e          op;

    assign pos_x      = s_tdata[15:0];
    assign pos_y      = s_tdata[31:16];
    assign rd_addr_in = s_tdata[46:32];

    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // pixel operation from the color register
    assign op = color_reg[7]     ? lrf_pkg::OP_XOR :
                (|color_reg[3:0]) ? lrf_pkg::OP_SET : lrf_pkg::OP_CLR;

    // scaled point: quotient, sign back on, optional flip about the last row
    assign sx   = negx_reg ? -PEN_W'(prodx_reg[DIV31_SHIFT +: QX_W])
                           :  PEN_W'(prodx_reg[DIV31_SHIFT +: QX_W]);
    assign sy_s = negy_reg ? -PEN_W'(prody_reg[DIV47_SHIFT +: QY_W])
                           :  PEN_W'(prody_reg[DIV47_SHIFT +: QY_W]);
    assign sy   = rev_reg ? sy_s : PEN_W'(lrf_pkg::MAX_Y) - sy_s;

    assign nx = clamp_coord(sx, lrf_pkg::MAX_X);
    assign ny = clamp_coord(sy, lrf_pkg::MAX_Y);
    assign ox = clamp_coord(pen_x_reg, lrf_pkg::MAX_X);
    assign oy = clamp_coord(pen_y_reg, lrf_pkg::MAX_Y);

    assign walk_start = state_reg == ST_FIX && func_reg == FUNC_DRAW;

    assign rd_req.valid = state_reg == ST_RD;
    assign rd_req.wr    = 1'b0;
    assign rd_req.addr  = LW'(raddr_reg);
    assign rd_req.mask  = 8'h00;
    assign mem_req      = walk_req.valid ? walk_req : rd_req;

    lrf_line_walker #(
        .FB_BYTES  (FB_BYTES),
        .ROW_BYTES (ROW_BYTES)
    ) u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (walk_start),
        .x1      (ox),
        .y1      (oy[YW-1:0]),
        .x2      (nx),
        .y2      (ny[YW-1:0]),
        .req     (walk_req),
        .stat    (walk_stat)
    );

    lrf_frame_mem #(
        .FB_BYTES (FB_BYTES)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .op      (op),
        .stat    (mem_stat)
    );

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        negx_next     = negx_reg;
        negy_next     = negy_reg;
        absx_next     = absx_reg;
        absy_next     = absy_reg;
        raddr_next    = raddr_reg;
        prodx_next    = prodx_reg;
        prody_next    = prody_reg;
        pen_x_next    = pen_x_reg;
        pen_y_next    = pen_y_reg;
        color_next    = color_reg;
        rev_next      = rev_reg;
        rdata_next    = rdata_reg;
        rcnt_next     = rcnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_COLOR_MODE: color_next = cfg_data;
                CFG_SCREEN_REV: rev_next   = cfg_data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR: begin
                if (!mem_stat.clearing) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tuser;
                    negx_next  = pos_x[15];
                    negy_next  = pos_y[15];
                    absx_next  = pos_x[15] ? 16'(-pos_x) : pos_x;
                    absy_next  = pos_y[15] ? 16'(-pos_y) : pos_y;
                    raddr_next = rd_addr_in;
                    rdata_next = '0;
                    rcnt_next  = '0;
                    if (s_tuser == FUNC_MOVE || s_tuser == FUNC_DRAW) begin
                        state_next = ST_SCALE;
                    end else if (s_tuser == FUNC_READ && LW'(rd_addr_in) < LW'(FB_BYTES)) begin
                        state_next = ST_RD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCALE: begin
                prodx_next = PROD_W'(absx_reg) * PROD_W'(DIV31_MUL);
                prody_next = PROD_W'(absy_reg) * PROD_W'(DIV47_MUL);
                state_next = ST_FIX;
            end
            ST_FIX: begin
                if (func_reg == FUNC_DRAW) begin
                    pen_x_next = PEN_W'(nx);
                    pen_y_next = PEN_W'(ny);
                    state_next = ST_DRAW;
                end else begin
                    pen_x_next = sx;
                    pen_y_next = sy;
                    state_next = ST_DONE;
                end
            end
            ST_DRAW: begin
                if (!walk_stat.busy) begin
                    rcnt_next  = walk_stat.count;
                    state_next = ST_DONE;
                end
            end
            ST_RD: begin
                state_next = ST_RDW;
            end
            ST_RDW: begin
                rdata_next = mem_stat.rd_value;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b0, rcnt_reg, rdata_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            pen_x_reg    <= '0;
            pen_y_reg    <= '0;
            color_reg    <= 8'h0F;
            rev_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pen_x_reg    <= pen_x_next;
            pen_y_reg    <= pen_y_next;
            color_reg    <= color_next;
            rev_reg      <= rev_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        func_reg    <= func_next;
        negx_reg    <= negx_next;
        negy_reg    <= negy_next;
        absx_reg    <= absx_next;
        absy_reg    <= absy_next;
        raddr_reg   <= raddr_next;
        prodx_reg   <= prodx_next;
        prody_reg   <= prody_next;
        rdata_reg   <= rdata_next;
        rcnt_reg    <= rcnt_next;
        m_tdata_reg <= m_tdata_next;
    end

    // no command taken while the framebuffer is still being zeroed
    `LRF_ASSERT_NOW(a_no_cmd_in_clear, mem_stat.clearing, !s_tready, "command accepted during clear")
    // pixel requests only come while a draw is running
    `LRF_ASSERT_NOW(a_pix_in_draw, walk_req.valid, state_reg == ST_DRAW, "stray pixel request")
    // a finished draw has plotted at least its start pixel and at most one row span
    `LRF_ASSERT_NOW(a_draw_count, state_reg == ST_DRAW && !walk_stat.busy,
        walk_stat.count != 0 && walk_stat.count <= CNT_W'(CNT_MAX), "bad pixel count")
    // an accepted command always leaves idle
    `LRF_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready, state_reg != ST_IDLE,
        "accepted word not processed")

endmodule
